>>> hw/rtl/gcd_lcm_unit_assert.svh
// assertion macros for the gcd/lcm unit
// plain concurrent assertions on one clock with a synchronous active-low reset
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

// same-cycle implication
`define GCL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gcl_pkg.sv
// shared types and sequencer codes for the gcd/lcm unit
// no dependencies
package gcl_pkg;

    typedef logic [2:0] t_state;

    localparam t_state ST_IDLE = 3'd0;  // waiting for a word
    localparam t_state ST_TWOS = 3'd1;  // strip common factors of two
    localparam t_state ST_GCD  = 3'd2;  // binary gcd on odd parts
    localparam t_state ST_DIV  = 3'd3;  // first operand / gcd, one bit a cycle
    localparam t_state ST_MUL  = 3'd4;  // quotient * second operand, shift-add

endpackage

>>> hw/rtl/gcd_lcm_unit.sv
// gcd/lcm unit: gcd by binary subtract-and-shift, lcm as (first / gcd) * second
// depends on gcl_pkg and gcd_lcm_unit_assert.svh
//
// usage
//   - drive i_first_operand / i_second_operand and raise start; the word is taken
//     at the rising edge where start is high and busy is low
//   - busy stays high while the word is worked on; no new word is taken then
//   - the result (o_gcd_value, o_lcm_value, o_both_zero) is shown for exactly one
//     cycle with o_done high; the receiver cannot stall, so it must take it then
//   - a new word may be started in the same cycle that o_done is high
// operation
//   - either operand zero: no division (gcd is the other operand, lcm is 0)
//   - otherwise: strip the common factors of two, then run the binary gcd shift,
//     subtract and swap steps, the restoring divider and the shift-add multiplier;
//     every subtract is followed by a shift; the single shared adder is used by the
//     gcd loop, the restoring divider and the shift-add multiplier in turn
// reset
//   - synchronous, active low; returns the sequencer to idle and drops o_done
`include "gcd_lcm_unit_assert.svh"

module gcd_lcm_unit #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OPERAND_BITS-1:0]   i_first_operand,
    input  logic [OPERAND_BITS-1:0]   i_second_operand,
    output logic                      o_done,
    output logic [OPERAND_BITS-1:0]   o_gcd_value,
    output logic [2*OPERAND_BITS-1:0] o_lcm_value,
    output logic                      o_both_zero
);

    localparam int N  = OPERAND_BITS;
    localparam int W  = OPERAND_BITS + 2;   // adder width: room for divider sign
    localparam int CW = $clog2(OPERAND_BITS);

    // control state
    gcl_pkg::t_state r_state, n_state;
    logic            r_done,  n_done;

    // working registers
    logic [N-1:0]    r_x,   n_x;     // first operand, dividend
    logic [N-1:0]    r_y,   n_y;     // second operand, multiplicand
    logic [N-1:0]    r_a,   n_a;     // gcd working pair
    logic [N-1:0]    r_b,   n_b;
    logic [CW-1:0]   r_k,   n_k;     // common factors of two
    logic [N-1:0]    r_gcd, n_gcd;   // full gcd, divisor
    logic [N-1:0]    r_rem, n_rem;   // divider remainder
    logic [N-1:0]    r_quo, n_quo;   // dividend/quotient, then low product half
    logic [N-1:0]    r_hi,  n_hi;    // high product half
    logic [CW-1:0]   r_cnt, n_cnt;   // bit step counter for div and mul

    // result registers
    logic [N-1:0]    r_gcd_out, n_gcd_out;
    logic [2*N-1:0]  r_lcm_out, n_lcm_out;
    logic            r_bz_out,  n_bz_out;

    // shared adder/subtractor
    logic [W-1:0]    unit_a;
    logic [W-1:0]    unit_b;
    logic            unit_sub;
    logic [W-1:0]    unit_res;
    logic            unit_neg;

    always_comb begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b1;
        case (r_state)
            gcl_pkg::ST_GCD: begin
                // a - b, sign gives the compare
                unit_a = {2'b00, r_a};
                unit_b = {2'b00, r_b};
            end
            gcl_pkg::ST_DIV: begin
                // trial subtract of the divisor from the shifted remainder
                unit_a = {1'b0, r_rem, r_quo[N-1]};
                unit_b = {2'b00, r_gcd};
            end
            gcl_pkg::ST_MUL: begin
                // add multiplicand into the high half when the low bit is set
                unit_a   = {2'b00, r_hi};
                unit_b   = r_quo[0] ? {2'b00, r_y} : '0;
                unit_sub = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign unit_res = unit_a + (unit_b ^ {W{unit_sub}}) + W'(unit_sub);
    assign unit_neg = unit_res[W-1];

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_x       = r_x;
        n_y       = r_y;
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        n_gcd     = r_gcd;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_hi      = r_hi;
        n_cnt     = r_cnt;
        n_gcd_out = r_gcd_out;
        n_lcm_out = r_lcm_out;
        n_bz_out  = r_bz_out;
        case (r_state)
            gcl_pkg::ST_IDLE: begin
                if (start) begin
                    n_x = i_first_operand;
                    n_y = i_second_operand;
                    n_a = i_first_operand;
                    n_b = i_second_operand;
                    n_k = '0;
                    if (i_first_operand == '0 || i_second_operand == '0) begin
                        // zero operand: answer at once, no division
                        n_gcd_out = i_first_operand | i_second_operand;
                        n_lcm_out = '0;
                        n_bz_out  = (i_first_operand == '0) && (i_second_operand == '0);
                        n_done    = 1'b1;
                    end else begin
                        n_state = gcl_pkg::ST_TWOS;
                    end
                end
            end
            gcl_pkg::ST_TWOS: begin
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + CW'(1);
                end else begin
                    n_state = gcl_pkg::ST_GCD;
                end
            end
            gcl_pkg::ST_GCD: begin
                if (r_a == '0) begin
                    // b holds the odd part of the gcd
                    n_gcd   = r_b << r_k;
                    n_rem   = '0;
                    n_quo   = r_x;
                    n_cnt   = '0;
                    n_state = gcl_pkg::ST_DIV;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (unit_neg) begin
                    // keep a >= b before subtracting
                    n_a = r_b;
                    n_b = r_a;
                end else begin
                    n_a = unit_res[N-1:0];
                end
            end
            gcl_pkg::ST_DIV: begin
                if (!unit_neg) begin
                    n_rem = unit_res[N-1:0];
                end else begin
                    n_rem = {r_rem[N-2:0], r_quo[N-1]};
                end
                n_quo = {r_quo[N-2:0], ~unit_neg};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(N - 1)) begin
                    n_cnt   = '0;
                    n_hi    = '0;
                    n_state = gcl_pkg::ST_MUL;
                end
            end
            gcl_pkg::ST_MUL: begin
                n_hi  = unit_res[N:1];
                n_quo = {unit_res[0], r_quo[N-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(N - 1)) begin
                    n_gcd_out = r_gcd;
                    n_lcm_out = {unit_res[N:1], unit_res[0], r_quo[N-1:1]};
                    n_bz_out  = 1'b0;
                    n_done    = 1'b1;
                    n_state   = gcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcl_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_gcd     <= n_gcd;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_hi      <= n_hi;
        r_cnt     <= n_cnt;
        r_gcd_out <= n_gcd_out;
        r_lcm_out <= n_lcm_out;
        r_bz_out  <= n_bz_out;
    end

    assign busy        = (r_state != gcl_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_gcd_value = r_gcd_out;
    assign o_lcm_value = r_lcm_out;
    assign o_both_zero = r_bz_out;

    // checks
    `GCL_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `GCL_ASSERT_NEXT(a_accept_moves, i_clk, i_rst_n, start && !busy, busy || o_done,
                     "word accepted but neither working nor answered")
    `GCL_ASSERT_SAME(a_gcd_nonzero, i_clk, i_rst_n, o_done && !o_both_zero,
                     o_gcd_value != '0, "zero gcd without both-zero flag")
    `GCL_ASSERT_SAME(a_both_zero_clean, i_clk, i_rst_n, o_done && o_both_zero,
                     (o_gcd_value == '0) && (o_lcm_value == '0), "both-zero result not cleared")

endmodule

>>> tb/gcd_lcm_unit_test.sv
// self-checking testbench for gcd_lcm_unit: directed table then random operand words
// needs only the gcd_lcm_unit rtl (and what it pulls in); predicts each result itself
`timescale 1ns / 1ps

module gcd_lcm_unit_test;

    localparam int OPERAND_BITS   = 31;
    localparam int LCM_BITS       = 2 * OPERAND_BITS;
    localparam int RANDOM_WORDS   = 1750;
    localparam int DRAIN_CYCLES   = 300;   // longer than the worst case latency of one word
    localparam int WATCHDOG_LIMIT = 3000;  // idle cycles with no word moving either way

    typedef logic [OPERAND_BITS-1:0] operand_t;
    typedef logic [LCM_BITS-1:0]     lcm_t;

    localparam operand_t OPND_MAX = {OPERAND_BITS{1'b1}};

    // one result word as the block shows it
    typedef struct packed {
        operand_t gcd_value;
        lcm_t     lcm_value;
        logic     both_zero;
    } gcd_lcm_t;

    // one row of the directed table; known_result only counts when has_known is set
    typedef struct packed {
        operand_t first_operand;
        operand_t second_operand;
        logic     has_known;
        gcd_lcm_t known_result;
    } stim_row_t;

    // clock, reset and block inputs, all known from time zero
    logic     i_clk            = 1'b0;
    logic     i_rst_n          = 1'b0;
    logic     start            = 1'b0;
    operand_t i_first_operand  = '0;
    operand_t i_second_operand = '0;

    logic     busy;
    logic     o_done;
    operand_t o_gcd_value;
    lcm_t     o_lcm_value;
    logic     o_both_zero;

    // results still owed by the block, oldest first
    gcd_lcm_t pending_results[$];
    int       error_count = 0;
    int       idle_cycles = 0;

    gcd_lcm_unit #(
        .OPERAND_BITS(OPERAND_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_first_operand (i_first_operand),
        .i_second_operand(i_second_operand),
        .o_done          (o_done),
        .o_gcd_value     (o_gcd_value),
        .o_lcm_value     (o_lcm_value),
        .o_both_zero     (o_both_zero)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // euclid remainder loop for the gcd; lcm as (first / gcd) * second at full width,
    // zero when either operand is zero, so the divide never sees a zero gcd
    function automatic gcd_lcm_t compute_gcd_lcm(input operand_t a, input operand_t b);
        operand_t x;
        operand_t y;
        operand_t keep;
        gcd_lcm_t r;
        x = a;
        y = b;
        while (x != '0) begin
            keep = x;
            x    = y % x;
            y    = keep;
        end
        r.gcd_value = y;
        r.both_zero = (a == '0) && (b == '0);
        if (a != '0 && b != '0)
            r.lcm_value = lcm_t'(a / y) * lcm_t'(b);
        else
            r.lcm_value = '0;
        return r;
    endfunction

    // present one word after a random gap and hold it until the block takes it;
    // start is only ever set once per time step, so back-to-back words keep it high
    task automatic send_word(input operand_t a, input operand_t b,
                             input logic use_known, input gcd_lcm_t known);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_first_operand  <= a;
        i_second_operand <= b;
        // busy read here is its value before this edge, so this is the accepting edge
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.insert(pending_results.size(),
                               use_known ? known : compute_gcd_lcm(a, b));
    endtask

    // hold off the sender until the block has nothing left in flight
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // random operand word, shaped so that gcd and lcm both get interesting values
    task automatic pick_operands(output operand_t a, output operand_t b);
        operand_t common;
        int       mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                // zero on one side or both
                a = $urandom_range(0, 1) ? '0 : operand_t'($urandom);
                b = (a != '0 || $urandom_range(0, 1)) ? '0 : operand_t'($urandom);
                if ($urandom_range(0, 1)) begin
                    common = a;
                    a      = b;
                    b      = common;
                end
            end
            1, 2, 3: begin
                // shared factor so the gcd is large and the lcm is reduced
                common = operand_t'($urandom_range(1, 65535));
                a      = operand_t'(common * $urandom_range(1, 32767));
                b      = operand_t'(common * $urandom_range(1, 32767));
            end
            4: begin
                // common powers of two exercise the factor-of-two stripping
                a = operand_t'($urandom) << $urandom_range(0, OPERAND_BITS - 1);
                b = operand_t'($urandom) << $urandom_range(0, OPERAND_BITS - 1);
            end
            5: begin
                a = operand_t'($urandom_range(0, 255));
                b = operand_t'($urandom_range(0, 255));
            end
            6: begin
                // near full scale
                a = OPND_MAX - operand_t'($urandom_range(0, 15));
                b = OPND_MAX - operand_t'($urandom_range(0, 15));
            end
            default: begin
                a = operand_t'($urandom);
                b = operand_t'($urandom);
            end
        endcase
    endtask

    // checker: every o_done cycle is one result word, compared with the oldest owed one
    always @(posedge i_clk) begin : check_results
        gcd_lcm_t want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: gcd %0d lcm %0d both_zero %0b",
                       o_gcd_value, o_lcm_value, o_both_zero);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_gcd_value !== want.gcd_value) begin
                    $error("gcd_value expected %0d actual %0d", want.gcd_value, o_gcd_value);
                    error_count++;
                end
                if (o_lcm_value !== want.lcm_value) begin
                    $error("lcm_value expected %0d actual %0d", want.lcm_value, o_lcm_value);
                    error_count++;
                end
                if (o_both_zero !== want.both_zero) begin
                    $error("both_zero expected %0b actual %0b", want.both_zero, o_both_zero);
                    error_count++;
                end
            end
        end
    end

    // watchdog: a word moving in or out clears it, anything else counts toward the limit
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gcd_lcm_unit_test NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t directed_rows[18];
        operand_t  a;
        operand_t  b;

        // zero cases, extremes and ones carry their result; the rest go to the predictor
        directed_rows = '{
            '{'0,           '0,           1'b1, '{'0,       '0,             1'b1}},
            '{'0,           OPND_MAX,     1'b1, '{OPND_MAX, '0,             1'b0}},
            '{OPND_MAX,     '0,           1'b1, '{OPND_MAX, '0,             1'b0}},
            '{'0,           operand_t'(1), 1'b1, '{operand_t'(1), '0,       1'b0}},
            '{operand_t'(1), '0,          1'b1, '{operand_t'(1), '0,        1'b0}},
            '{operand_t'(1), operand_t'(1), 1'b1, '{operand_t'(1), lcm_t'(1), 1'b0}},
            '{OPND_MAX,     OPND_MAX,     1'b1, '{OPND_MAX, lcm_t'(OPND_MAX), 1'b0}},
            '{operand_t'(1), OPND_MAX,    1'b1, '{operand_t'(1), lcm_t'(OPND_MAX), 1'b0}},
            '{OPND_MAX,     operand_t'(1), 1'b1, '{operand_t'(1), lcm_t'(OPND_MAX), 1'b0}},
            '{OPND_MAX,     OPND_MAX - operand_t'(1), 1'b0, '0},
            '{OPND_MAX - operand_t'(1), OPND_MAX,     1'b0, '0},
            '{operand_t'(12), operand_t'(18), 1'b0, '0},
            '{operand_t'(31'h4000_0000), operand_t'(31'h2000_0000), 1'b0, '0},
            '{operand_t'(31'h4000_0000), operand_t'(3), 1'b0, '0},
            '{operand_t'(31'h5555_5555), operand_t'(31'h2AAA_AAAA), 1'b0, '0},
            '{operand_t'(2147483629), operand_t'(2147483587), 1'b0, '0},
            '{operand_t'(31'h7FFF_FFFE), operand_t'(31'h4000_0000), 1'b0, '0},
            '{operand_t'(46340), operand_t'(46341), 1'b0, '0}
        };

        // reset held low at the start, once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].first_operand, directed_rows[i].second_operand,
                      directed_rows[i].has_known, directed_rows[i].known_result);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // a couple of full drains so a word also starts from a truly idle block
            if (n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3)
                wait_until_drained();
            pick_operands(a, b);
            // some stretches run with no sender gaps at all
            if (n % 200 < 30) begin
                start            <= 1'b1;
                i_first_operand  <= a;
                i_second_operand <= b;
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
                pending_results.insert(pending_results.size(), compute_gcd_lcm(a, b));
            end else begin
                send_word(a, b, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let any stray result word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("gcd_lcm_unit_test OK");
        else
            $display("gcd_lcm_unit_test NOT OK");
        $finish;
    end

endmodule
